// File: sv/hvbv_pkg.sv
// Package for the hypervector bundle vote block: payload structs, field widths
// and the control struct passed from the top level to the merge stage.
// No dependencies; compile first.
package hvbv_pkg;

   // Bits per streamed hypervector word, one lane per bit
   localparam int WORD_BITS = 64;
   localparam int BUNDLE_WIDTH = 4;
   localparam int WORD_INDEX_WIDTH = 7;
   // Running distance sums and per-word popcounts
   localparam int SUM_WIDTH = 14;
   localparam int PCNT_WIDTH = 7;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

   typedef enum logic {
      KIND_ADD   = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [BUNDLE_WIDTH-1:0]     bundle_index;
      logic [WORD_INDEX_WIDTH-1:0] word_index;
      logic [WORD_BITS-1:0]        key_word;
      logic [WORD_BITS-1:0]        plus_word;
      logic [WORD_BITS-1:0]        minus_word;
      logic                        vote_positive;
      logic                        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [BUNDLE_WIDTH-1:0] result_bundle;
      logic                    choose_positive;
      logic [SUM_WIDTH-1:0]    distance_plus;
      logic [SUM_WIDTH-1:0]    distance_minus;
   } rsp_payload_type;

   // Merge stage controls
   typedef struct packed {
      logic pc_load;     // capture this word's popcounts
      logic hit;         // word addressed a stored row; otherwise counts are zero
      logic sum_update;  // fold popcounts into running sums
      logic sum_clear;   // final word delivered: restart the sums
   } merge_ctl_type;

endpackage

// File: sv/hvbv_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on hvbv_pkg for the payload structs.
interface hvbv_req_if;
   import hvbv_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hvbv_rsp_if;
   import hvbv_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/hvbv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module hvbv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/hvbv_lane.sv
// One bit lane: saturating vote counter update and majority threshold.
// No package dependency; instantiated once per word bit by the top level.
module hvbv_lane #(
   parameter int CNT_WIDTH = 6,
   parameter int VOTE_LIMIT = 31
) (
   input  logic signed [CNT_WIDTH-1:0] count,
   input  logic                        bound,
   output logic signed [CNT_WIDTH-1:0] count_next,
   output logic                        positive
);

   localparam logic signed [CNT_WIDTH-1:0] LimPos = CNT_WIDTH'(VOTE_LIMIT);
   localparam logic signed [CNT_WIDTH-1:0] LimNeg = -LimPos;
   localparam logic signed [CNT_WIDTH-1:0] One = CNT_WIDTH'(1);

   // Step toward the bound bit, holding at the limits
   always_comb begin
      count_next = count;
      if (bound) begin
         if (count < LimPos) begin
            count_next = count + One;
         end
      end else if (count > LimNeg) begin
         count_next = count - One;
      end
   end

   // Strictly positive counter votes one
   assign positive = !count[CNT_WIDTH-1] && (|count);

endmodule

// File: sv/hvbv_merge.sv
// Merge stage: popcounts of the thresholded word against both class bindings,
// and the two saturating running distance sums. Depends on hvbv_pkg.
module hvbv_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  hvbv_pkg::merge_ctl_type          ctl,
   input  logic [hvbv_pkg::WORD_BITS-1:0]   thr_word,
   input  logic [hvbv_pkg::WORD_BITS-1:0]   key_word,
   input  logic [hvbv_pkg::WORD_BITS-1:0]   plus_word,
   input  logic [hvbv_pkg::WORD_BITS-1:0]   minus_word,
   output logic [hvbv_pkg::SUM_WIDTH-1:0]   plus_next,
   output logic [hvbv_pkg::SUM_WIDTH-1:0]   minus_next
);
   import hvbv_pkg::*;

   localparam int ByteCount = WORD_BITS / 8;

   // Byte-wise counts, then a short sum over the bytes
   function automatic logic [PCNT_WIDTH-1:0] count_ones(input logic [WORD_BITS-1:0] w);
      logic [3:0]            byte_cnt;
      logic [PCNT_WIDTH-1:0] total;
      total = '0;
      for (int b = 0; b < ByteCount; b++) begin
         byte_cnt = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt = byte_cnt + 4'(w[b*8+i]);
         end
         total = total + PCNT_WIDTH'(byte_cnt);
      end
      return total;
   endfunction

   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] sum,
                                                    input logic [PCNT_WIDTH-1:0] pc);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, sum} + (SUM_WIDTH+1)'(pc);
      return s[SUM_WIDTH] ? SUM_MAX : s[SUM_WIDTH-1:0];
   endfunction

   logic [PCNT_WIDTH-1:0] pc_plus_ff;
   logic [PCNT_WIDTH-1:0] pc_minus_ff;
   logic [SUM_WIDTH-1:0]  sum_plus_ff;
   logic [SUM_WIDTH-1:0]  sum_minus_ff;
   logic [PCNT_WIDTH-1:0] pc_plus_in;
   logic [PCNT_WIDTH-1:0] pc_minus_in;

   // Per-word distances; a word outside the stored range adds nothing
   assign pc_plus_in  = ctl.hit ? count_ones(thr_word ^ key_word ^ plus_word) : '0;
   assign pc_minus_in = ctl.hit ? count_ones(thr_word ^ key_word ^ minus_word) : '0;

   // Candidate sums after this word
   assign plus_next  = sat_add(sum_plus_ff, pc_plus_ff);
   assign minus_next = sat_add(sum_minus_ff, pc_minus_ff);

   always_ff @(posedge clock) begin
      if (ctl.pc_load) begin
         pc_plus_ff  <= pc_plus_in;
         pc_minus_ff <= pc_minus_in;
      end
      if (reset) begin
         sum_plus_ff  <= '0;
         sum_minus_ff <= '0;
      end else if (ctl.sum_clear) begin
         sum_plus_ff  <= '0;
         sum_minus_ff <= '0;
      end else if (ctl.sum_update) begin
         sum_plus_ff  <= plus_next;
         sum_minus_ff <= minus_next;
      end
   end

endmodule

// File: sv/hypervector_bundle_vote.sv
// Top level of the hypervector bundle vote block. Depends on hvbv_pkg,
// hvbv_if, hvbv_ram, hvbv_lane and hvbv_merge.
//
// Usage:
//   req_chan carries one transaction per 64-bit hypervector word. An add
//   transaction moves the 64 vote counters of that word of the bundle up or
//   down by one. A query transaction thresholds those counters and adds the
//   Hamming distances to key^plus and key^minus into two shared sums; a query
//   marked last_word returns one rsp_chan transaction and restarts the sums.
//   Timing: the counter row memory is read when a transaction is accepted,
//   and an add writes its updated row back in the EXEC state; a query
//   passes a popcount stage (EXEC), then a sum stage (ACC). req_chan.ready
//   is high only in the idle state, so a new transaction is not accepted
//   until the last one is done. A final query raises rsp_chan.valid from
//   the output register after its sum stage, once that register is free.
//   Reset: after reset the block zeroes the counter memory one row per cycle,
//   all NUM_BUNDLES * DIMENSION / 64 rows (2048 with the defaults), with ready
//   held low. The response sits in an output register: further words are
//   accepted while it waits; only a second final query stalls until the
//   first response is taken.
module hypervector_bundle_vote #(
   parameter int DIMENSION = 8192,
   parameter int NUM_BUNDLES = 16,
   parameter int VOTE_LIMIT = 31
) (
   input logic         clock,
   input logic         reset,
   hvbv_req_if.sink    req_chan,
   hvbv_rsp_if.source  rsp_chan
);
   import hvbv_pkg::*;

   localparam int Words = DIMENSION / WORD_BITS;
   localparam int Depth = NUM_BUNDLES * Words;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(VOTE_LIMIT + 1) + 1;
   localparam int RowWidth = WORD_BITS * CW;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_ACC
   } state_type;

   state_type       state_ff, state_in;
   req_payload_type item_ff, item_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic            hit_ff, hit_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 req_hit;
   logic [AW-1:0]        rd_addr;
   logic                 slot_free;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [RowWidth-1:0]  ram_wr_data;
   logic [RowWidth-1:0]  ram_rd_data;
   logic [RowWidth-1:0]  new_row;
   logic [WORD_BITS-1:0] bound_word;
   logic [WORD_BITS-1:0] thr_word;
   merge_ctl_type        merge_ctl;
   logic [SUM_WIDTH-1:0] plus_next;
   logic [SUM_WIDTH-1:0] minus_next;

   // Handshake and row addressing
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_hit = (32'(req_chan.payload.bundle_index) < NUM_BUNDLES)
                 && (32'(req_chan.payload.word_index) < Words);
   assign rd_addr = AW'(AW'(req_chan.payload.bundle_index) * AW'(Words))
                  + AW'(req_chan.payload.word_index);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Counter row memory
   hvbv_ram #(
      .WIDTH(RowWidth),
      .DEPTH(Depth)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (req_accept),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // Bound vote word for an add
   assign bound_word = item_ff.key_word ^
                       (item_ff.vote_positive ? item_ff.plus_word : item_ff.minus_word);

   // One lane per word bit
   for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
      hvbv_lane #(
         .CNT_WIDTH (CW),
         .VOTE_LIMIT(VOTE_LIMIT)
      ) u_lane (
         .count     (ram_rd_data[g*CW +: CW]),
         .bound     (bound_word[g]),
         .count_next(new_row[g*CW +: CW]),
         .positive  (thr_word[g])
      );
   end

   // Distance merge
   hvbv_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (merge_ctl),
      .thr_word  (thr_word),
      .key_word  (item_ff.key_word),
      .plus_word (item_ff.plus_word),
      .minus_word(item_ff.minus_word),
      .plus_next (plus_next),
      .minus_next(minus_next)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      merge_ctl    = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = new_row;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(Depth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_chan.payload;
               addr_in  = rd_addr;
               hit_in   = req_hit;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.kind == KIND_ADD) begin
               ram_wr_en = hit_ff;
               state_in  = ST_IDLE;
            end else begin
               merge_ctl.pc_load = 1'b1;
               merge_ctl.hit     = hit_ff;
               state_in          = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!item_ff.last_word) begin
               merge_ctl.sum_update = 1'b1;
               state_in             = ST_IDLE;
            end else if (slot_free) begin
               merge_ctl.sum_clear    = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_in.result_bundle   = item_ff.bundle_index;
               rsp_in.choose_positive = (plus_next < minus_next);
               rsp_in.distance_plus   = plus_next;
               rsp_in.distance_minus  = minus_next;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Row writes come only from the clearing pass or an in-range add
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR)
                 || (state_ff == ST_EXEC && item_ff.kind == KIND_ADD && hit_ff))
      else $error("counter row written outside clear pass or add");

   // An accepted transaction is processed in the following cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction not executed next cycle");

   // A response appears only after the sum stage of a final query
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_ACC && item_ff.kind == KIND_QUERY
                                        && item_ff.last_word))
      else $error("response without a final query");

   // Decision bit agrees with the distances it is sent with
   a_choose: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.payload.choose_positive ==
                         (rsp_chan.payload.distance_plus < rsp_chan.payload.distance_minus))
      else $error("choose_positive inconsistent with distances");

endmodule
